[hdl/selm_pkg.sv]
`timescale 1ns / 1ps
// selm_pkg: sizes, entry layout, cell commands and result codes of the lock manager
// no dependencies
package selm_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int RESOURCE_BITS = 8;
  localparam int CLIENT_BITS = 4;
  localparam int TAG_BITS = 8;
  localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

  localparam int IN_BITS = 1 + TAG_BITS + CLIENT_BITS + RESOURCE_BITS + 3;
  localparam int IN_BYTES_BITS = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 + TAG_BITS;
  localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam logic OP_LOCK = 1'b0;
  localparam logic OP_DISCONNECT = 1'b1;

  localparam logic [1:0] KIND_GRANTED = 2'd0;
  localparam logic [1:0] KIND_REFUSED = 2'd1;
  localparam logic [1:0] KIND_STOLEN = 2'd2;
  localparam logic [1:0] KIND_FULL = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic                     gone;
    logic                     held;
    logic [CLIENT_BITS-1:0]   client;
    logic [RESOURCE_BITS-1:0] resource;
    logic                     mode;
    logic [TAG_BITS-1:0]      tag;
  } entry_t;

  typedef struct packed {
    logic [RESOURCE_BITS-1:0] resource;
    logic [CLIENT_BITS-1:0]   client;
  } cell_key_t;

  typedef struct packed {
    logic waiting;
    logic held_any;
    logic held_ex;
  } cell_flags_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_RIGHT,
    CELL_TAKE_LEFT,
    CELL_LOAD,
    CELL_MARK
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_STEAL,
    ST_CHECK,
    ST_PLACE,
    ST_QUEUE,
    ST_FIND,
    ST_FINISH
  } state_t;

endpackage

[hdl/selm_cell.sv]
`timescale 1ns / 1ps
// selm_cell: one lock entry of the age-ordered chain, shifts to either neighbor
// depends on selm_pkg
module selm_cell import selm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_op_t    op,
  input  entry_t      left,
  input  entry_t      right,
  input  entry_t      load_val,
  input  cell_key_t   key,
  output entry_t      entry,
  output cell_flags_t flags
);

  logic live_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      unique case (op)
        CELL_HOLD: begin
        end
        CELL_TAKE_RIGHT: begin
          entry <= right;
        end
        CELL_TAKE_LEFT: begin
          entry <= left;
        end
        CELL_LOAD: begin
          entry <= load_val;
        end
        CELL_MARK: begin
          if (entry.valid && entry.client == key.client) begin
            entry.gone <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // entries of a disconnected client no longer count
  assign live_match = entry.valid && !entry.gone && entry.resource == key.resource;
  assign flags.waiting = live_match && !entry.held;
  assign flags.held_any = live_match && entry.held;
  assign flags.held_ex = live_match && entry.held && entry.mode;

endmodule

[hdl/shared_exclusive_lock_manager.sv]
`timescale 1ns / 1ps
// shared_exclusive_lock_manager: lock table held as a chain of cells in age order
// a request walks the chain one cell per cycle, unless a result waits for the output port;
// a steal request walks it twice, a disconnect restarts its search after each removed entry
// throughput: one request at a time, set by the sequencer stepping the chain pointer
// reset: rst synchronous active high, empties the table and the result register
module shared_exclusive_lock_manager import selm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // operation, request_tag, client_id, resource_id, lock_mode, steal_flag, if_available_flag
  input  logic [IN_BYTES_BITS-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // result_kind, result_tag, zero fill
  output logic [OUT_BYTES_BITS-1:0] m_tdata,
  output logic                      m_tlast
);

  state_t state, state_next;
  logic [CNT_BITS-1:0] p, p_next, cnt, cnt_next;
  logic [RESOURCE_BITS-1:0] cur_res, cur_res_next;

  logic req_op, req_mode, req_steal;
  logic [TAG_BITS-1:0] req_tag;
  logic [CLIENT_BITS-1:0] req_client;

  logic pend_v;
  logic [1:0] pend_kind;
  logic [TAG_BITS-1:0] pend_tag;

  entry_t cells [TABLE_ENTRIES];
  entry_t rights [TABLE_ENTRIES];
  entry_t lefts [TABLE_ENTRIES];
  cell_flags_t flags [TABLE_ENTRIES];
  cell_op_t cop [TABLE_ENTRIES];
  entry_t load_val, new_entry, head;
  cell_key_t key;
  cell_flags_t head_flags;

  logic [TABLE_ENTRIES-1:0] waiting_v, held_any_v, held_ex_v;
  logic waiting_or, held_any_or, held_ex_or;
  logic out_free, can_emit, emit, flush;
  logic [1:0] emit_kind;
  logic [TAG_BITS-1:0] emit_tag;
  logic do_mark, do_front, do_append, do_remove, do_move;

  assign key.resource = cur_res;
  assign key.client = req_client;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign rights[i] = '0;
    end else begin : g_mid
      assign rights[i] = cells[i+1];
    end
    if (i == 0) begin : g_first
      assign lefts[i] = '0;
    end else begin : g_rest
      assign lefts[i] = cells[i-1];
    end
    selm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (cop[i]),
      .left     (lefts[i]),
      .right    (rights[i]),
      .load_val (load_val),
      .key      (key),
      .entry    (cells[i]),
      .flags    (flags[i])
    );
    assign waiting_v[i] = flags[i].waiting;
    assign held_any_v[i] = flags[i].held_any;
    assign held_ex_v[i] = flags[i].held_ex;
  end

  assign waiting_or = |waiting_v;
  assign held_any_or = |held_any_v;
  assign held_ex_or = |held_ex_v;

  assign head = cells[p[IDX_BITS-1:0]];
  assign head_flags = flags[p[IDX_BITS-1:0]];

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.gone = 1'b0;
    new_entry.held = 1'b0;
    new_entry.client = req_client;
    new_entry.resource = cur_res;
    new_entry.mode = req_mode;
    new_entry.tag = req_tag;
  end

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign can_emit = !pend_v || out_free;

  always_comb begin
    state_next = state;
    p_next = p;
    cnt_next = cnt;
    cur_res_next = cur_res;
    emit = 1'b0;
    emit_kind = KIND_GRANTED;
    emit_tag = head.tag;
    flush = 1'b0;
    do_mark = 1'b0;
    do_front = 1'b0;
    do_append = 1'b0;
    do_remove = 1'b0;
    do_move = 1'b0;
    load_val = new_entry;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cur_res_next = s_tdata[1+TAG_BITS+CLIENT_BITS +: RESOURCE_BITS];
          p_next = '0;
          if (s_tdata[0] == OP_DISCONNECT) begin
            state_next = ST_MARK;
          end else if (s_tdata[IN_BITS-2]) begin
            state_next = ST_STEAL;
          end else if (s_tdata[IN_BITS-1]) begin
            state_next = ST_CHECK;
          end else begin
            state_next = ST_PLACE;
          end
        end
      end
      ST_MARK: begin
        do_mark = 1'b1;
        p_next = '0;
        state_next = ST_FIND;
      end
      ST_STEAL: begin
        if (p == cnt) begin
          state_next = ST_PLACE;
        end else if (head_flags.held_any) begin
          if (can_emit) begin
            emit = 1'b1;
            emit_kind = KIND_STOLEN;
            do_remove = 1'b1;
            cnt_next = cnt - 1'b1;
          end
        end else begin
          p_next = p + 1'b1;
        end
      end
      ST_CHECK: begin
        if (waiting_or || (req_mode ? held_any_or : held_ex_or)) begin
          if (can_emit) begin
            emit = 1'b1;
            emit_kind = KIND_REFUSED;
            emit_tag = req_tag;
            state_next = ST_FINISH;
          end
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (cnt == CNT_BITS'(TABLE_ENTRIES)) begin
          if (can_emit) begin
            emit = 1'b1;
            emit_kind = KIND_FULL;
            emit_tag = req_tag;
            state_next = ST_FINISH;
          end
        end else begin
          do_front = req_steal;
          do_append = !req_steal;
          cnt_next = cnt + 1'b1;
          p_next = '0;
          state_next = ST_QUEUE;
        end
      end
      ST_QUEUE: begin
        if (p == cnt) begin
          p_next = '0;
          state_next = (req_op == OP_DISCONNECT) ? ST_FIND : ST_FINISH;
        end else if (head_flags.waiting) begin
          if (!(head.mode ? held_any_or : held_ex_or)) begin
            if (can_emit) begin
              // granted head moves to the back, next waiter slides into place
              emit = 1'b1;
              emit_kind = KIND_GRANTED;
              do_move = 1'b1;
              load_val = head;
              load_val.held = 1'b1;
            end
          end else begin
            p_next = '0;
            state_next = (req_op == OP_DISCONNECT) ? ST_FIND : ST_FINISH;
          end
        end else begin
          p_next = p + 1'b1;
        end
      end
      ST_FIND: begin
        if (p == cnt) begin
          state_next = ST_FINISH;
        end else if (head.gone) begin
          cur_res_next = head.resource;
          do_remove = 1'b1;
          cnt_next = cnt - 1'b1;
          p_next = '0;
          state_next = ST_QUEUE;
        end else begin
          p_next = p + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!pend_v) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          flush = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      cop[i] = CELL_HOLD;
      if (do_mark) begin
        cop[i] = CELL_MARK;
      end else if (do_front) begin
        cop[i] = (i == 0) ? CELL_LOAD : CELL_TAKE_LEFT;
      end else if (do_append) begin
        if (CNT_BITS'(i) == cnt) cop[i] = CELL_LOAD;
      end else if (do_remove) begin
        if (CNT_BITS'(i) >= p) cop[i] = CELL_TAKE_RIGHT;
      end else if (do_move) begin
        if (CNT_BITS'(i) == cnt - 1'b1) begin
          cop[i] = CELL_LOAD;
        end else if (CNT_BITS'(i) >= p && CNT_BITS'(i) < cnt - 1'b1) begin
          cop[i] = CELL_TAKE_RIGHT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      p <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      p <= p_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_res <= cur_res_next;
    if (s_tvalid && s_tready) begin
      req_op <= s_tdata[0];
      req_tag <= s_tdata[1 +: TAG_BITS];
      req_client <= s_tdata[1+TAG_BITS +: CLIENT_BITS];
      req_mode <= s_tdata[IN_BITS-3];
      req_steal <= s_tdata[IN_BITS-2];
    end
  end

  // one result held back so the last of a request can carry tlast
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        if (pend_v) begin
          m_tvalid <= 1'b1;
          m_tdata <= OUT_BYTES_BITS'({pend_tag, pend_kind});
          m_tlast <= 1'b0;
        end else if (m_tvalid && m_tready) begin
          m_tvalid <= 1'b0;
        end
        pend_v <= 1'b1;
        pend_kind <= emit_kind;
        pend_tag <= emit_tag;
      end else if (flush) begin
        m_tvalid <= 1'b1;
        m_tdata <= OUT_BYTES_BITS'({pend_tag, pend_kind});
        m_tlast <= 1'b1;
        pend_v <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[hdl/selm_checker.sv]
`timescale 1ns / 1ps
// selm_checker: port-level checks on the lock manager, bound to the top level
// depends on selm_pkg and shared_exclusive_lock_manager
module selm_checker import selm_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [IN_BYTES_BITS-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [OUT_BYTES_BITS-1:0] m_tdata,
  input logic                      m_tlast
);

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another in flight");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // refusal and table full end a request
  a_final_kinds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == KIND_REFUSED || m_tdata[1:0] == KIND_FULL) |-> m_tlast)
    else $error("refusal or table full not last");

  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_BYTES_BITS-1:OUT_BITS] == '0)
    else $error("result fill bits set");

endmodule

bind shared_exclusive_lock_manager selm_checker u_selm_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for shared_exclusive_lock_manager
// runs a directed table and then random lock and disconnect requests
// depends on selm_pkg and shared_exclusive_lock_manager
module testbench;
  import selm_pkg::*;

  typedef struct {
    logic                     op;
    logic [TAG_BITS-1:0]      tag;
    logic [CLIENT_BITS-1:0]   client;
    logic [RESOURCE_BITS-1:0] resource;
    logic                     mode;
    logic                     steal;
    logic                     ifavail;
    bit                       known;
    logic [1:0]               first_kind;
  } lock_req_t;

  typedef struct {
    logic [1:0]          kind;
    logic [TAG_BITS-1:0] tag;
    logic                last;
  } lock_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_BYTES_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_BYTES_BITS-1:0] m_tdata;
  logic m_tlast;

  // predictor copy of the lock table
  bit                       lk_valid[TABLE_ENTRIES];
  bit                       lk_held[TABLE_ENTRIES];
  logic [CLIENT_BITS-1:0]   lk_client[TABLE_ENTRIES];
  logic [RESOURCE_BITS-1:0] lk_res[TABLE_ENTRIES];
  logic                     lk_mode[TABLE_ENTRIES];
  logic [TAG_BITS-1:0]      lk_tag[TABLE_ENTRIES];
  int                       age_order[TABLE_ENTRIES];

  lock_result_t expected_results[$];
  lock_result_t new_results[$];
  lock_req_t    requests[$];
  bit           failed = 1'b0;

  shared_exclusive_lock_manager DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic void add_result(logic [1:0] kind, logic [TAG_BITS-1:0] tag);
    lock_result_t r;
    r.kind = kind;
    r.tag = tag;
    r.last = 1'b0;
    new_results.push_back(r);
  endfunction

  function automatic void reorder(int e, bit to_front);
    int tmp[TABLE_ENTRIES];
    int n;
    n = 0;
    if (to_front) begin
      tmp[n] = e;
      n++;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (age_order[i] != e) begin
        tmp[n] = age_order[i];
        n++;
      end
    end
    if (!to_front) tmp[n] = e;
    age_order = tmp;
  endfunction

  function automatic bit can_grant(logic [RESOURCE_BITS-1:0] res, logic mode);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (lk_valid[i] && lk_held[i] && lk_res[i] == res && (mode || lk_mode[i]))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit has_waiters(logic [RESOURCE_BITS-1:0] res);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (lk_valid[i] && !lk_held[i] && lk_res[i] == res) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void grant_waiters(logic [RESOURCE_BITS-1:0] res);
    int head;
    forever begin
      head = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (head < 0 && lk_valid[age_order[i]] && !lk_held[age_order[i]] &&
            lk_res[age_order[i]] == res)
          head = age_order[i];
      end
      if (head < 0 || !can_grant(res, lk_mode[head])) return;
      lk_held[head] = 1'b1;
      reorder(head, 1'b0);
      add_result(KIND_GRANTED, lk_tag[head]);
    end
  endfunction

  // computes the results of one request and updates the predicted table
  function automatic void predict_lock_results(lock_req_t q);
    int snap[TABLE_ENTRIES];
    bit dropped[TABLE_ENTRIES];
    logic [RESOURCE_BITS-1:0] dres[TABLE_ENTRIES];
    int slot;
    int e;
    new_results.delete();
    snap = age_order;
    if (q.op == OP_DISCONNECT) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        dropped[i] = lk_valid[i] && lk_client[i] == q.client;
        dres[i] = lk_res[i];
        if (dropped[i]) lk_valid[i] = 1'b0;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (dropped[snap[i]]) grant_waiters(dres[snap[i]]);
      end
    end else begin
      slot = -1;
      if (q.steal) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          e = snap[i];
          if (lk_valid[e] && lk_held[e] && lk_res[e] == q.resource) begin
            lk_valid[e] = 1'b0;
            add_result(KIND_STOLEN, lk_tag[e]);
          end
        end
      end else if (q.ifavail && (has_waiters(q.resource) || !can_grant(q.resource, q.mode)))
      begin
        add_result(KIND_REFUSED, q.tag);
        slot = -2;
      end
      if (slot == -1) begin
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
          if (!lk_valid[i]) slot = i;
        end
        if (slot < 0) begin
          add_result(KIND_FULL, q.tag);
        end else begin
          lk_valid[slot] = 1'b1;
          lk_held[slot] = 1'b0;
          lk_client[slot] = q.client;
          lk_res[slot] = q.resource;
          lk_mode[slot] = q.mode;
          lk_tag[slot] = q.tag;
          reorder(slot, q.steal);
          grant_waiters(q.resource);
        end
      end
    end
    if (new_results.size() > 0) new_results[new_results.size() - 1].last = 1'b1;
  endfunction

  function automatic lock_req_t make_req(logic op, logic [7:0] tag, logic [3:0] client,
                                         logic [7:0] res, logic mode, logic steal,
                                         logic ifavail, bit known, logic [1:0] kind);
    lock_req_t q;
    q.op = op; q.tag = tag; q.client = client; q.resource = res;
    q.mode = mode; q.steal = steal; q.ifavail = ifavail;
    q.known = known; q.first_kind = kind;
    return q;
  endfunction

  function automatic lock_req_t random_req();
    lock_req_t q;
    q.op = ($urandom_range(0, 7) == 0) ? OP_DISCONNECT : OP_LOCK;
    q.tag = TAG_BITS'($urandom_range(0, 255));
    q.client = ($urandom_range(0, 3) == 0) ? CLIENT_BITS'($urandom_range(0, 15)) :
                                             CLIENT_BITS'($urandom_range(0, 3));
    q.resource = ($urandom_range(0, 7) == 0) ? RESOURCE_BITS'($urandom_range(0, 255)) :
                                               RESOURCE_BITS'($urandom_range(0, 3));
    q.mode = 1'($urandom_range(0, 1));
    q.steal = ($urandom_range(0, 7) == 0);
    q.ifavail = ($urandom_range(0, 3) == 0);
    q.known = 1'b0;
    q.first_kind = KIND_GRANTED;
    return q;
  endfunction

  // request source
  initial begin
    lock_req_t q;
    int gap;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      lk_valid[i] = 1'b0;
      lk_held[i] = 1'b0;
      age_order[i] = i;
    end
    requests.push_back(make_req(OP_LOCK, 8'd0, 4'd1, 8'd0, 1'b1, 1'b0, 1'b0, 1'b1,
                                KIND_GRANTED));
    requests.push_back(make_req(OP_LOCK, 8'd1, 4'd2, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1,
                                KIND_REFUSED));
    requests.push_back(make_req(OP_LOCK, 8'd2, 4'd2, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                KIND_GRANTED));
    // steal from the exclusive holder, queued shared follows
    requests.push_back(make_req(OP_LOCK, 8'd3, 4'd3, 8'd0, 1'b0, 1'b1, 1'b1, 1'b1,
                                KIND_STOLEN));
    requests.push_back(make_req(OP_DISCONNECT, 8'd4, 4'd3, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                KIND_GRANTED));
    requests.push_back(make_req(OP_DISCONNECT, 8'd5, 4'd9, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                KIND_GRANTED));
    requests.push_back(make_req(OP_LOCK, 8'hff, 4'd15, 8'hff, 1'b1, 1'b0, 1'b0, 1'b1,
                                KIND_GRANTED));
    // fill the table with waiters on one resource
    for (int i = 0; i < 15; i++)
      requests.push_back(make_req(OP_LOCK, 8'(16 + i), 4'(5 + i % 2), 8'hff, i % 3 == 0,
                                  1'b0, 1'b0, 1'b0, KIND_GRANTED));
    requests.push_back(make_req(OP_LOCK, 8'haa, 4'd7, 8'h55, 1'b0, 1'b0, 1'b0, 1'b1,
                                KIND_FULL));
    requests.push_back(make_req(OP_DISCONNECT, 8'd6, 4'd15, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                KIND_GRANTED));
    requests.push_back(make_req(OP_DISCONNECT, 8'd7, 4'd5, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                KIND_GRANTED));
    requests.push_back(make_req(OP_DISCONNECT, 8'd8, 4'd6, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                KIND_GRANTED));
    for (int i = 0; i < 100; i++) requests.push_back(random_req());

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (requests[n]) begin
      q = requests[n];
      gap = (n % 40 < 8) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= {q.ifavail, q.steal, q.mode, q.resource, q.client, q.tag, q.op};
      do @(posedge clk); while (!s_tready);
      predict_lock_results(q);
      if (q.known && (new_results.size() == 0 || new_results[0].kind != q.first_kind)) begin
        $error("result_kind: expected %0d, actual %0d", q.first_kind,
               new_results.size() ? new_results[0].kind : 2'bx);
        failed = 1'b1;
      end
      foreach (new_results[k]) expected_results.push_back(new_results[k]);
    end
    s_tvalid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result sink with random stalls
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    lock_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d tag %0d", m_tdata[1:0], m_tdata[9:2]);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tdata[1:0] !== exp_r.kind) begin
          $error("result_kind: expected %0d, actual %0d", exp_r.kind, m_tdata[1:0]);
          failed = 1'b1;
        end
        if (m_tdata[9:2] !== exp_r.tag) begin
          $error("result_tag: expected %0d, actual %0d", exp_r.tag, m_tdata[9:2]);
          failed = 1'b1;
        end
        if (m_tlast !== exp_r.last) begin
          $error("last_result: expected %0d, actual %0d", exp_r.last, m_tlast);
          failed = 1'b1;
        end
      end
    end
  end

endmodule
